>>> sv/lfuc_pkg.sv
`timescale 1ns / 1ps

package lfuc_pkg;

  // fixed field widths
  localparam int TAG_W     = 32;
  localparam int TOTAL_W   = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int WAY_OUT_W = 3;

  // parameter defaults
  localparam int DEF_NUM_SETS    = 256;
  localparam int DEF_NUM_WAYS    = 8;
  localparam int DEF_COUNT_WIDTH = 16;

  // register reset values
  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd5;
  localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd8;
  localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_INDEX_BITS  = 2'd1,
    REG_WAYS_IN_USE = 2'd2
  } cfg_reg_t;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_LAST = 5'b00100,
    S_UPD  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic start;
    logic sample;
  } scan_ctl_t;

  typedef struct packed {
    logic hit_found;
    logic inv_found;
  } scan_flags_t;

  function automatic logic [TOTAL_W-1:0] sat_total_inc(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + TOTAL_W'(1);
  endfunction

endpackage

>>> sv/lfuc_tag_store.sv
`timescale 1ns / 1ps

module lfuc_tag_store #(
  parameter int LINE_DEPTH  = 2048,
  parameter int AGE_DEPTH   = 256,
  parameter int ENT_W       = 11,
  parameter int SET_W       = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [ENT_W-1:0]            rd_addr,
  output logic                        rd_valid,
  output logic [lfuc_pkg::TAG_W-1:0]  rd_tag,
  output logic [COUNT_WIDTH-1:0]      rd_count,
  input  logic                        wr_en,
  input  logic [ENT_W-1:0]            wr_addr,
  input  logic [lfuc_pkg::TAG_W-1:0]  wr_tag,
  input  logic [COUNT_WIDTH-1:0]      wr_count,
  input  logic [SET_W-1:0]            age_addr,
  input  logic                        age_we,
  input  logic [COUNT_WIDTH-1:0]      age_wdata,
  output logic [COUNT_WIDTH-1:0]      age_rdata,
  output logic                        busy
);

  localparam int CLR_W = $clog2(LINE_DEPTH + 1);

  logic                       valid_mem [LINE_DEPTH];
  logic [lfuc_pkg::TAG_W-1:0] tag_mem   [LINE_DEPTH];
  logic [COUNT_WIDTH-1:0]     cnt_mem   [LINE_DEPTH];
  logic [COUNT_WIDTH-1:0]     age_mem   [AGE_DEPTH];

  logic             busy_r;
  logic [CLR_W-1:0] clr_r;

  logic                       l_we;
  logic [ENT_W-1:0]           l_addr;
  logic                       l_valid;
  logic [lfuc_pkg::TAG_W-1:0] l_tag;
  logic [COUNT_WIDTH-1:0]     l_count;
  logic                       a_we;
  logic [SET_W-1:0]           a_addr;
  logic [COUNT_WIDTH-1:0]     a_data;

  // clearing sweep owns the write ports after reset
  always_comb begin
    if (busy_r) begin
      l_we    = 1'b1;
      l_addr  = clr_r[ENT_W-1:0];
      l_valid = 1'b0;
      l_tag   = '0;
      l_count = '0;
      a_we    = (clr_r < CLR_W'(AGE_DEPTH));
      a_addr  = clr_r[SET_W-1:0];
      a_data  = '0;
    end else begin
      l_we    = wr_en;
      l_addr  = wr_addr;
      l_valid = 1'b1;
      l_tag   = wr_tag;
      l_count = wr_count;
      a_we    = age_we;
      a_addr  = age_addr;
      a_data  = age_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      clr_r <= clr_r + CLR_W'(1);
      if (clr_r == CLR_W'(LINE_DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      valid_mem[l_addr] <= l_valid;
      tag_mem[l_addr]   <= l_tag;
      cnt_mem[l_addr]   <= l_count;
    end
    if (rd_en) begin
      rd_valid <= valid_mem[rd_addr];
      rd_tag   <= tag_mem[rd_addr];
      rd_count <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      age_mem[a_addr] <= a_data;
    end
    age_rdata <= age_mem[age_addr];
  end

  assign busy = busy_r;

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !rd_en && !wr_en && !age_we)
    else $error("tag store accessed during clearing sweep");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> !busy_r)
    else $error("clearing sweep restarted without reset");

  a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(clr_r) == CLR_W'(LINE_DEPTH - 1))
    else $error("clearing sweep ended early");

endmodule

>>> sv/lfuc_scan_unit.sv
`timescale 1ns / 1ps

module lfuc_scan_unit #(
  parameter int WAY_W       = 3,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfuc_pkg::scan_ctl_t         ctl,
  input  logic [WAY_W-1:0]            cur_way,
  input  logic [lfuc_pkg::TAG_W-1:0]  key_tag,
  input  logic                        rd_valid,
  input  logic [lfuc_pkg::TAG_W-1:0]  rd_tag,
  input  logic [COUNT_WIDTH-1:0]      rd_count,
  output lfuc_pkg::scan_flags_t       flags,
  output logic [WAY_W-1:0]            hit_way,
  output logic [COUNT_WIDTH-1:0]      hit_count,
  output logic [WAY_W-1:0]            inv_way,
  output logic [WAY_W-1:0]            min_way,
  output logic [COUNT_WIDTH-1:0]      min_count
);

  lfuc_pkg::scan_flags_t  flags_r;
  logic [WAY_W-1:0]       hit_way_r;
  logic [COUNT_WIDTH-1:0] hit_count_r;
  logic [WAY_W-1:0]       inv_way_r;
  logic [WAY_W-1:0]       min_way_r;
  logic [COUNT_WIDTH-1:0] min_count_r;

  logic is_hit;
  logic is_inv;
  logic is_min;

  // one way per beat: tag match, first free way, running minimum
  assign is_hit = ctl.sample && rd_valid && (rd_tag == key_tag) && !flags_r.hit_found;
  assign is_inv = ctl.sample && !rd_valid && !flags_r.inv_found;
  assign is_min = ctl.sample && ((cur_way == '0) || (rd_count < min_count_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (ctl.start) begin
      flags_r <= '0;
    end else begin
      if (is_hit) begin
        flags_r.hit_found <= 1'b1;
      end
      if (is_inv) begin
        flags_r.inv_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_hit) begin
      hit_way_r   <= cur_way;
      hit_count_r <= rd_count;
    end
    if (is_inv) begin
      inv_way_r <= cur_way;
    end
    if (is_min) begin
      min_way_r   <= cur_way;
      min_count_r <= rd_count;
    end
  end

  assign flags     = flags_r;
  assign hit_way   = hit_way_r;
  assign hit_count = hit_count_r;
  assign inv_way   = inv_way_r;
  assign min_way   = min_way_r;
  assign min_count = min_count_r;

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> !flags_r.hit_found && !flags_r.inv_found)
    else $error("scan start did not clear flags");

  a_first_hit_kept: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.hit_found && !ctl.start |=> flags_r.hit_found && $stable(hit_way_r))
    else $error("later match overwrote first hit");

  a_first_inv_kept: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.inv_found && !ctl.start |=> $stable(inv_way_r))
    else $error("later free way overwrote first one");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.sample && !ctl.start |=> $stable(flags_r))
    else $error("flags changed without a beat");

endmodule

>>> sv/lfu_set_assoc_read_cache.sv
`timescale 1ns / 1ps

// Set-associative tag store with least-frequently-used replacement. Each beat
// on the in_ channel is a read or write access to a 32-bit byte address; each
// gives exactly one beat on the out_ channel with hit, way, evicted and the
// four running totals (saturating). Reads look up the set picked by the
// address, bump the hit way's use count, or on a miss fill the first free way
// or evict the lowest-count way (lowest way wins ties); the evicted count
// becomes the set's age and the new line starts at age + 1. Writes only bump
// the write and write-miss totals. A write goes straight to the result beat; a
// read scans W ways (ways_in_use, 0 taken as 1 and anything above NUM_WAYS as
// NUM_WAYS) through the single tag-array read port: one way is read and
// compared per cycle through one shared compare unit, then an update step
// writes back count, tag and valid. A finished beat waits while the previous
// result is still stalled in the output register. After reset a clearing
// pass over 2^floor(log2 NUM_SETS) * NUM_WAYS lines (2048 at the defaults)
// runs with in_stall high; configuration writes are taken during it. The
// user must write configuration only while no access is in flight; the block
// itself does not enforce it.

module lfu_set_assoc_read_cache #(
  parameter int NUM_SETS    = lfuc_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS    = lfuc_pkg::DEF_NUM_WAYS,
  parameter int COUNT_WIDTH = lfuc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // access channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [31:0]                     in_address,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [lfuc_pkg::WAY_OUT_W-1:0]  out_way,
  output logic                            out_evicted,
  output logic [lfuc_pkg::TOTAL_W-1:0]    out_read_total,
  output logic [lfuc_pkg::TOTAL_W-1:0]    out_read_miss_total,
  output logic [lfuc_pkg::TOTAL_W-1:0]    out_write_total,
  output logic [lfuc_pkg::TOTAL_W-1:0]    out_write_miss_total,
  // configuration
  input  logic                            cfg_we,
  input  logic [lfuc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfuc_pkg::CFG_W-1:0]      cfg_data
);

  // largest b with 2^b <= NUM_SETS
  localparam int IDX_CAP    = $clog2(NUM_SETS + 1) - 1;
  localparam int AGE_DEPTH  = 1 << IDX_CAP;
  localparam int SET_W      = (IDX_CAP > 0) ? IDX_CAP : 1;
  localparam int LINE_DEPTH = AGE_DEPTH * NUM_WAYS;
  localparam int ENT_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int WAY_W      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WC_W       = $clog2(NUM_WAYS + 1);
  localparam int TW         = lfuc_pkg::TOTAL_W;
  localparam int CW         = lfuc_pkg::CFG_W;

  lfuc_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] offset_bits_r;
  logic [CW-1:0] index_bits_r;
  logic [CW-1:0] ways_in_use_r;

  logic [TW-1:0] reads_r;
  logic [TW-1:0] read_misses_r;
  logic [TW-1:0] writes_r;
  logic [TW-1:0] write_misses_r;

  // per-access working registers
  logic [SET_W-1:0]           set_r;
  logic [lfuc_pkg::TAG_W-1:0] tag_r;
  logic [WC_W-1:0]            ways_eff_r;
  logic [WAY_W-1:0]           issue_r;
  logic [WAY_W-1:0]           samp_way_r;
  logic                       sample_r;
  logic                       res_hit_r;
  logic [WAY_W-1:0]           res_way_r;
  logic                       res_evicted_r;

  // output register
  logic                         out_valid_r;
  logic                         out_hit_r;
  logic [lfuc_pkg::WAY_OUT_W-1:0] out_way_r;
  logic                         out_evicted_r;
  logic [TW-1:0]                out_reads_r;
  logic [TW-1:0]                out_read_misses_r;
  logic [TW-1:0]                out_writes_r;
  logic [TW-1:0]                out_write_misses_r;

  // address split
  logic [CW-1:0]              ib_eff;
  logic [CW:0]                shamt;
  logic [31:0]                set_full;
  logic [lfuc_pkg::TAG_W-1:0] tag_full;
  logic [CW:0]                ways_ext;
  logic [WC_W-1:0]            ways_eff;

  logic in_accept;
  logic out_load;
  logic scan_last;

  // tag store and scan unit hookup
  logic                       st_busy;
  logic                       st_rd_en;
  logic [ENT_W-1:0]           st_rd_addr;
  logic                       st_rd_valid;
  logic [lfuc_pkg::TAG_W-1:0] st_rd_tag;
  logic [COUNT_WIDTH-1:0]     st_rd_count;
  logic                       st_wr_en;
  logic [ENT_W-1:0]           st_wr_addr;
  logic [COUNT_WIDTH-1:0]     st_wr_count;
  logic                       st_age_we;
  logic [COUNT_WIDTH-1:0]     st_age_rdata;

  lfuc_pkg::scan_ctl_t   scan_ctl;
  lfuc_pkg::scan_flags_t scan_flags;
  logic [WAY_W-1:0]       sc_hit_way;
  logic [COUNT_WIDTH-1:0] sc_hit_count;
  logic [WAY_W-1:0]       sc_inv_way;
  logic [WAY_W-1:0]       sc_min_way;
  logic [COUNT_WIDTH-1:0] sc_min_count;

  // update decision
  logic [WAY_W-1:0]       victim_way;
  logic                   miss_evict;
  logic [COUNT_WIDTH-1:0] age_base;
  logic [COUNT_WIDTH-1:0] fill_count;
  logic [COUNT_WIDTH-1:0] hit_count_inc;
  logic [WAY_W-1:0]       upd_way;
  logic [WAY_W+2:0]       way_ext;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != lfuc_pkg::S_IDLE) || st_busy;
  assign out_load  = (state_r == lfuc_pkg::S_DONE) && (!out_valid_r || !out_stall);

  // index bits clamp to the sets that exist; tag is everything above
  always_comb begin
    ib_eff   = (index_bits_r > CW'(IDX_CAP)) ? CW'(IDX_CAP) : index_bits_r;
    shamt    = {1'b0, offset_bits_r} + {1'b0, ib_eff};
    set_full = (in_address >> offset_bits_r) & ((32'd1 << ib_eff) - 32'd1);
    tag_full = in_address >> shamt;
    ways_ext = {1'b0, ways_in_use_r};
    if (ways_ext == '0) begin
      ways_eff = WC_W'(1);
    end else if (ways_ext > (CW + 1)'(NUM_WAYS)) begin
      ways_eff = WC_W'(NUM_WAYS);
    end else begin
      ways_eff = WC_W'(ways_ext);
    end
  end

  assign scan_last = (WC_W'(issue_r) + WC_W'(1)) == ways_eff_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfuc_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_command == lfuc_pkg::CMD_WRITE) ? lfuc_pkg::S_DONE
                                                          : lfuc_pkg::S_SCAN;
        end
      end
      lfuc_pkg::S_SCAN: begin
        if (scan_last) begin
          state_nxt = lfuc_pkg::S_LAST;
        end
      end
      lfuc_pkg::S_LAST: state_nxt = lfuc_pkg::S_UPD;
      lfuc_pkg::S_UPD:  state_nxt = lfuc_pkg::S_DONE;
      lfuc_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = lfuc_pkg::S_IDLE;
        end
      end
      default: state_nxt = lfuc_pkg::S_IDLE;
    endcase
  end

  // one way read per scan cycle; read data is registered and comes back the next cycle
  assign st_rd_en   = (state_r == lfuc_pkg::S_SCAN);
  assign st_rd_addr = ENT_W'(set_r) * ENT_W'(NUM_WAYS) + ENT_W'(issue_r);

  assign scan_ctl.start  = in_accept;
  assign scan_ctl.sample = sample_r;

  // miss: first free way, else lowest count; evicted count becomes the age
  always_comb begin
    victim_way    = scan_flags.inv_found ? sc_inv_way : sc_min_way;
    miss_evict    = !scan_flags.inv_found;
    age_base      = miss_evict ? sc_min_count : st_age_rdata;
    fill_count    = (age_base == '1) ? age_base : age_base + COUNT_WIDTH'(1);
    hit_count_inc = (sc_hit_count == '1) ? sc_hit_count : sc_hit_count + COUNT_WIDTH'(1);
    upd_way       = scan_flags.hit_found ? sc_hit_way : victim_way;
  end

  assign st_wr_en    = (state_r == lfuc_pkg::S_UPD);
  assign st_wr_addr  = ENT_W'(set_r) * ENT_W'(NUM_WAYS) + ENT_W'(upd_way);
  assign st_wr_count = scan_flags.hit_found ? hit_count_inc : fill_count;
  assign st_age_we   = (state_r == lfuc_pkg::S_UPD) && !scan_flags.hit_found && miss_evict;

  assign way_ext = {3'b000, res_way_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lfuc_pkg::S_IDLE;
      offset_bits_r  <= lfuc_pkg::OFFSET_BITS_RST;
      index_bits_r   <= lfuc_pkg::INDEX_BITS_RST;
      ways_in_use_r  <= lfuc_pkg::WAYS_IN_USE_RST;
      reads_r        <= '0;
      read_misses_r  <= '0;
      writes_r       <= '0;
      write_misses_r <= '0;
      sample_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sample_r <= (state_r == lfuc_pkg::S_SCAN);

      if (cfg_we) begin
        unique case (cfg_index)
          lfuc_pkg::REG_OFFSET_BITS: offset_bits_r <= cfg_data;
          lfuc_pkg::REG_INDEX_BITS:  index_bits_r  <= cfg_data;
          lfuc_pkg::REG_WAYS_IN_USE: ways_in_use_r <= cfg_data;
          default: ;
        endcase
      end

      if (in_accept) begin
        if (in_command == lfuc_pkg::CMD_WRITE) begin
          writes_r       <= lfuc_pkg::sat_total_inc(writes_r);
          write_misses_r <= lfuc_pkg::sat_total_inc(write_misses_r);
        end else begin
          reads_r <= lfuc_pkg::sat_total_inc(reads_r);
        end
      end
      if (state_r == lfuc_pkg::S_UPD && !scan_flags.hit_found) begin
        read_misses_r <= lfuc_pkg::sat_total_inc(read_misses_r);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      set_r         <= set_full[SET_W-1:0];
      tag_r         <= tag_full;
      ways_eff_r    <= ways_eff;
      issue_r       <= '0;
      res_hit_r     <= 1'b0;
      res_way_r     <= '0;
      res_evicted_r <= 1'b0;
    end
    if (state_r == lfuc_pkg::S_SCAN) begin
      issue_r    <= issue_r + WAY_W'(1);
      samp_way_r <= issue_r;
    end
    if (state_r == lfuc_pkg::S_UPD) begin
      res_hit_r     <= scan_flags.hit_found;
      res_way_r     <= upd_way;
      res_evicted_r <= !scan_flags.hit_found && miss_evict;
    end
    if (out_load) begin
      out_hit_r          <= res_hit_r;
      out_way_r          <= way_ext[2:0];
      out_evicted_r      <= res_evicted_r;
      out_reads_r        <= reads_r;
      out_read_misses_r  <= read_misses_r;
      out_writes_r       <= writes_r;
      out_write_misses_r <= write_misses_r;
    end
  end

  lfuc_tag_store #(
    .LINE_DEPTH  (LINE_DEPTH),
    .AGE_DEPTH   (AGE_DEPTH),
    .ENT_W       (ENT_W),
    .SET_W       (SET_W),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (st_rd_en),
    .rd_addr   (st_rd_addr),
    .rd_valid  (st_rd_valid),
    .rd_tag    (st_rd_tag),
    .rd_count  (st_rd_count),
    .wr_en     (st_wr_en),
    .wr_addr   (st_wr_addr),
    .wr_tag    (tag_r),
    .wr_count  (st_wr_count),
    .age_addr  (set_r),
    .age_we    (st_age_we),
    .age_wdata (sc_min_count),
    .age_rdata (st_age_rdata),
    .busy      (st_busy)
  );

  lfuc_scan_unit #(
    .WAY_W       (WAY_W),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .cur_way   (samp_way_r),
    .key_tag   (tag_r),
    .rd_valid  (st_rd_valid),
    .rd_tag    (st_rd_tag),
    .rd_count  (st_rd_count),
    .flags     (scan_flags),
    .hit_way   (sc_hit_way),
    .hit_count (sc_hit_count),
    .inv_way   (sc_inv_way),
    .min_way   (sc_min_way),
    .min_count (sc_min_count)
  );

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_way              = out_way_r;
  assign out_evicted          = out_evicted_r;
  assign out_read_total       = out_reads_r;
  assign out_read_miss_total  = out_read_misses_r;
  assign out_write_total      = out_writes_r;
  assign out_write_miss_total = out_write_misses_r;

  a_miss_le_reads: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_read_misses_r <= out_reads_r)
    else $error("read misses exceed reads");

  a_write_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_writes_r == out_write_misses_r)
    else $error("write totals diverged");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evicted_r))
    else $error("hit reported with eviction");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lfuc_pkg::S_DONE))
    else $error("result beat raised outside done state");

endmodule
